@@ rtl/rdsc_pkg.sv @@
`default_nettype none
package rdsc_pkg;

    localparam int unsigned RADIX_W = 6;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DEC_BASE    = 6'd10;

    localparam logic [ADDR_W-1:0] ADDR_RADIX = 2'd0;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd65;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_READ = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_BASE)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_ALPHA + CHAR_W'(d - DEC_BASE);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/radix_digit_string_converter.sv @@
// Sequence: each digit comes from the shared restoring divider and goes into the digit store;
// then each character is read from the digit store and then output, held while out_stall is high.
// A zero value skips the divider.
// Throughput: one transaction at a time; in_stall stays high until the last character leaves.
// Reset: asynchronous, active low; radix returns to 10, the sequencer to idle.
`default_nettype none
module radix_digit_string_converter
    import rdsc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [31:0]        value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [CHAR_W-1:0]  digit_char,
    output logic                    last_digit
);

    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int unsigned IDX_W = $clog2(VALUE_WIDTH);

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       rd_idx_next;
    logic [RADIX_W-1:0]     rd_data_reg;
    logic [RADIX_W-1:0]     digit_mem [VALUE_WIDTH];

    logic [RADIX_W-1:0]     radix;
    logic [VALUE_WIDTH-1:0] val_ext;
    logic                   in_accept;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [RADIX_W-1:0]     div_rem;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [RADIX_W-1:0]     mem_wdata;
    logic                   more_digits;

    rdsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .radix   (radix)
    );

    rdsc_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign val_ext      = VALUE_WIDTH'(value);
    assign in_stall     = (state_reg != S_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign more_digits  = (div_quot != '0) && (cnt_reg != CNT_W'(VALUE_WIDTH - 1));
    assign div_dividend = (state_reg == S_IDLE) ? val_ext : div_quot;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        div_start   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = cnt_reg[IDX_W-1:0];
        mem_wdata   = div_rem;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (val_ext == '0)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = '0;
                        mem_wdata   = '0;
                        cnt_next    = CNT_W'(1);
                        rd_idx_next = '0;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (more_digits)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = cnt_reg[IDX_W-1:0];
                        state_next  = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    if (rd_idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= digit_mem[rd_idx_reg];
        end
    end

    assign out_valid  = (state_reg == S_EMIT);
    assign digit_char = digit_to_char(rd_data_reg);
    assign last_digit = (rd_idx_reg == '0);

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(VALUE_WIDTH))
        else $error("digit count beyond value width");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_digit) |=> (state_reg == S_IDLE))
        else $error("sequencer not idle after last character");

    a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
        (radix >= RADIX_MIN) && (radix <= RADIX_MAX))
        else $error("radix outside 2..36");
`endif

endmodule
`default_nettype wire

@@ rtl/rdsc_cfg.sv @@
`default_nettype none
module rdsc_cfg
    import rdsc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    output logic      [RADIX_W-1:0] radix
);

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_next;
    logic [RADIX_W-1:0] wr_raw;
    logic               wr_en;

    assign wr_raw = pwdata[RADIX_W-1:0];
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_RADIX);

    always_comb
    begin
        radix_next = radix_reg;
        if (wr_en)
        begin
            priority if (wr_raw < RADIX_MIN)
            begin
                radix_next = RADIX_MIN;
            end
            else if (wr_raw > RADIX_MAX)
            begin
                radix_next = RADIX_MAX;
            end
            else
            begin
                radix_next = wr_raw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RADIX) ? DATA_W'(radix_reg) : '0;
    assign radix  = radix_reg;

endmodule
`default_nettype wire

@@ rtl/rdsc_div.sv @@
`default_nettype none
module rdsc_div
    import rdsc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [RADIX_W-1:0]     divisor,
    output logic                        done,
    output logic      [VALUE_WIDTH-1:0] quotient,
    output logic      [RADIX_W-1:0]     remainder
);

    localparam int unsigned STEP_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] quo_next;
    logic [RADIX_W-1:0]     rem_reg;
    logic [RADIX_W-1:0]     rem_next;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    logic [RADIX_W:0]       trial;
    logic [RADIX_W:0]       diff;
    logic                   fits;

    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_next = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none
module testbench;
    import rdsc_pkg::*;

    localparam int unsigned STALL_LIMIT = 6000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned PHASES = 10;
    localparam int unsigned PHASE_ITEMS = 22;
    localparam logic [ADDR_W-1:0] ADDR_LAST = {ADDR_W{1'b1}};

    typedef struct packed {
        logic [CHAR_W-1:0] glyph;
        logic              last_flag;
    } digit_t;

    class digit_scoreboard;
        logic [RADIX_W-1:0] radix;
        digit_t             pending_digits[$];
        int unsigned        errors;
        int unsigned        values_noted;
        int unsigned        digits_checked;

        function new();
            radix = RADIX_RESET;
            errors = 0;
            values_noted = 0;
            digits_checked = 0;
        endfunction

        function void write_radix(logic [DATA_W-1:0] data);
            logic [RADIX_W-1:0] r;
            r = data[RADIX_W-1:0];
            if (r < RADIX_MIN)
                r = RADIX_MIN;
            if (r > RADIX_MAX)
                r = RADIX_MAX;
            radix = r;
        endfunction

        function void note_value(logic [31:0] v);
            logic [RADIX_W-1:0] rems[$];
            logic [31:0]        n;
            digit_t             d;
            n = v;
            if (n == 0)
                rems.push_back('0);
            while (n != 0)
            begin
                rems.push_back(RADIX_W'(n % radix));
                n = n / radix;
            end
            for (int k = rems.size() - 1; k >= 0; k--)
            begin
                if (rems[k] < DEC_BASE)
                    d.glyph = CHAR_ZERO + CHAR_W'(rems[k]);
                else
                    d.glyph = CHAR_ALPHA + CHAR_W'(rems[k] - DEC_BASE);
                d.last_flag = (k == 0);
                pending_digits.push_back(d);
            end
            values_noted++;
        endfunction

        function void check_digit(logic [CHAR_W-1:0] glyph, logic last_flag);
            digit_t d;
            if (pending_digits.size() == 0)
            begin
                $error("digit_char %0d (last_digit %0b) with no conversion pending",
                       glyph, last_flag);
                errors++;
                return;
            end
            d = pending_digits.pop_front();
            digits_checked++;
            if (glyph !== d.glyph)
            begin
                $error("digit_char: expected %0d, got %0d", d.glyph, glyph);
                errors++;
            end
            if (last_flag !== d.last_flag)
            begin
                $error("last_digit: expected %0b, got %0b", d.last_flag, last_flag);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_digits.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [31:0]       value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;

    digit_scoreboard sb;
    int unsigned     idle_max = 6;
    int unsigned     quiet_cycles = 0;
    int unsigned     radix_settings = 0;
    bit              running = 1'b0;

    radix_digit_string_converter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (running)
        begin
            if (out_valid && !out_stall)
                sb.check_digit(digit_char, last_digit);
            if (in_valid && !in_stall)
                sb.note_value(value);
            if ((out_valid && !out_stall) || (in_valid && !in_stall)
                || (psel && penable && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transaction", quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned n;
        wait (running);
        forever
        begin
            n = $urandom_range(idle_max, 0);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_RADIX)
        begin
            sb.write_radix(data);
            radix_settings++;
        end
        @(posedge clk);
    endtask

    task automatic apb_check_radix();
        logic [DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_RADIX;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== DATA_W'(sb.radix))
        begin
            $error("radix: expected %0d, got %0d", sb.radix, rd);
            sb.errors++;
        end
        @(posedge clk);
    endtask

    task automatic set_radix(input logic [DATA_W-1:0] data);
        apb_write(ADDR_RADIX, data);
        apb_check_radix();
    endtask

    task automatic convert(input logic [31:0] v);
        int unsigned gap;
        gap = $urandom_range(idle_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain(input int unsigned settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        longint unsigned p;
        int unsigned     k;
        p = 1;
        case ($urandom_range(5, 0))
            0: return $urandom_range(32'(sb.radix) * 32'(sb.radix), 0);
            1:
            begin
                k = $urandom_range(31, 1);
                repeat (k)
                    if (p * sb.radix <= 64'hFFFF_FFFF)
                        p = p * sb.radix;
                return $urandom_range(1, 0) ? 32'(p) : 32'(p - 1);
            end
            2: return $urandom_range(1, 0) ? 32'h0 : 32'hFFFF_FFFF;
            3: return $urandom >> $urandom_range(31, 0);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [DATA_W-1:0] data;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        running = 1'b1;

        apb_check_radix();
        convert(32'd0);
        convert(32'd1);
        convert(32'd9);
        convert(32'd10);
        convert(32'hFFFF_FFFF);
        convert(32'h8000_0000);
        convert(32'h5555_5555);
        convert(32'hAAAA_AAAA);
        drain(4);

        set_radix(32'd0);
        convert(32'hFFFF_FFFF);
        convert(32'd0);
        convert(32'd1);
        convert(32'h8000_0000);
        drain(4);

        set_radix(32'd63);
        convert(32'd35);
        convert(32'd36);
        convert(32'hFFFF_FFFF);
        convert(32'd0);
        drain(4);

        set_radix(32'd1);
        convert(32'd6);
        drain(4);
        set_radix(32'd37);
        convert(32'd1295);
        drain(4);

        apb_write(ADDR_W'($urandom_range(ADDR_LAST, ADDR_RADIX + 1)), $urandom);
        apb_check_radix();
        set_radix(32'hFFFF_FFD0);
        convert(32'd15);
        convert(32'd255);
        drain(4);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 5)
                0: data = DATA_W'(RADIX_MIN);
                1: data = DATA_W'(RADIX_MAX);
                2: data = $urandom;
                3: data = $urandom_range(63, 0);
                default: data = $urandom_range(RADIX_MAX, RADIX_MIN);
            endcase
            if ($urandom_range(1, 0))
                apb_write(ADDR_W'($urandom_range(ADDR_LAST, ADDR_RADIX + 1)), $urandom);
            set_radix(data);
            idle_max = (ph % 3 == 1) ? 0 : 6;
            for (int i = 0; i < PHASE_ITEMS; i++)
                convert(pick_value());
            drain(4);
        end

        drain(SETTLE_CYCLES);
        $display("converted %0d values into %0d checked characters over %0d radix writes",
                 sb.values_noted, sb.digits_checked, radix_settings);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
